// ----- hw/rtl/hybrid_huffman_fallback_encoder_assert.svh -----
// Assertion macros shared by the encoder RTL.
`ifndef HYBRID_HUFFMAN_FALLBACK_ENCODER_ASSERT_SVH
`define HYBRID_HUFFMAN_FALLBACK_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HHFE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hhfe assertion failed");

// Next-cycle implication, disabled during reset.
`define HHFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hhfe assertion failed");

`endif

// ----- hw/rtl/hhfe_pkg.sv -----
// Types and constants shared by the hybrid Huffman / fallback encoder.
`timescale 1ns / 1ps

package hhfe_pkg;

    localparam int SYM_W       = 32;
    localparam int CODE_W      = 32;
    localparam int LEN_W       = 6;
    localparam int SLOT_W      = 6;
    localparam int FBW_W       = 6;
    localparam int BSZ_W       = 16;
    localparam int CNT_W       = 16;
    localparam int OFS_W       = 48;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int MAX_RESULTS = 4;
    localparam int RES_IDX_W   = 2;
    localparam int RES_CNT_W   = 3;

    localparam logic [BSZ_W-1:0] DEFAULT_BLOCK = 16'd1024;
    localparam logic [FBW_W-1:0] DEFAULT_FBW   = 6'd32;
    localparam logic [FBW_W-1:0] MAX_FBW       = 6'd32;

    localparam logic [CFG_INDEX_W-1:0] CFG_FALLBACK_WIDTH = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_SIZE     = 4'd1;

    typedef enum logic [1:0] {
        CMD_LOAD      = 2'd0,
        CMD_SYMBOL    = 2'd1,
        CMD_END_ENTRY = 2'd2,
        CMD_FLUSH     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_HUFF     = 2'd0,
        KIND_FALLBACK = 2'd1,
        KIND_RECORD   = 2'd2,
        KIND_TOTALS   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       data_byte;
        logic [3:0]       valid_bits;
        logic [CNT_W-1:0] huff_count;
        logic [CNT_W-1:0] entry_bits;
        logic             block_start;
        logic [OFS_W-1:0] hi_offset;
        logic [OFS_W-1:0] lo_offset;
    } result_t;

    // Item after the table lookup stage.
    typedef struct packed {
        cmd_t              cmd;
        logic [SYM_W-1:0]  sym;
        logic              hit;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } lookup_t;

endpackage

// ----- hw/rtl/hhfe_lookup.sv -----
// Code table: associative key match, code memory and the lookup stage register.
`timescale 1ns / 1ps
`include "hybrid_huffman_fallback_encoder_assert.svh"

module hhfe_lookup #(
    parameter int TABLE_SLOTS  = 64,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  hhfe_pkg::cmd_t                   cmd,
    input  logic [hhfe_pkg::SYM_W-1:0]       sym,
    input  logic [hhfe_pkg::SLOT_W-1:0]      slot,
    input  logic [hhfe_pkg::CODE_W-1:0]      code_bits,
    input  logic [hhfe_pkg::LEN_W-1:0]       code_length,
    output hhfe_pkg::lookup_t                look
);

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int WORD_W = hhfe_pkg::LEN_W + hhfe_pkg::CODE_W;
    localparam logic [hhfe_pkg::LEN_W-1:0] MAX_LEN = hhfe_pkg::LEN_W'(MAX_CODE_LEN);

    logic [hhfe_pkg::SYM_W-1:0] key_reg [TABLE_SLOTS];
    logic [WORD_W-1:0]          code_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0]     valid_reg;
    logic [TABLE_SLOTS-1:0]     valid_next;

    logic [TABLE_SLOTS-1:0]     match_vec;
    logic [IDX_W-1:0]           match_idx;
    logic                       match_hit;

    logic [31:0]                slot_wide;
    logic                       slot_ok;
    logic [IDX_W-1:0]           slot_idx;
    logic [hhfe_pkg::LEN_W-1:0] clen;
    logic                       do_load;

    hhfe_pkg::cmd_t             cmd_reg;
    logic [hhfe_pkg::SYM_W-1:0] sym_reg;
    logic                       hit_reg;
    logic [WORD_W-1:0]          word_reg;

    assign slot_wide = {{(32 - hhfe_pkg::SLOT_W){1'b0}}, slot};
    assign slot_ok   = slot_wide < 32'(TABLE_SLOTS);
    assign slot_idx  = slot_wide[IDX_W-1:0];
    assign clen      = (code_length > MAX_LEN) ? MAX_LEN : code_length;
    assign do_load   = adv && (cmd == hhfe_pkg::CMD_LOAD) && slot_ok;

    // Compare every slot, lowest-numbered live match wins.
    always_comb
    begin
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            match_vec[i] = valid_reg[i] && (key_reg[i] == sym);
        end
        match_idx = '0;
        match_hit = 1'b0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                match_idx = IDX_W'(i);
                match_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (do_load)
        begin
            valid_next[slot_idx] = (clen != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (adv)
            begin
                hit_reg <= match_hit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            key_reg[slot_idx] <= sym;
        end
        if (adv)
        begin
            cmd_reg <= cmd;
            sym_reg <= sym;
        end
    end

    // Code memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            code_mem[slot_idx] <= {clen, code_bits};
        end
        if (adv)
        begin
            word_reg <= code_mem[match_idx];
        end
    end

    always_comb
    begin
        look.cmd  = cmd_reg;
        look.sym  = sym_reg;
        look.hit  = hit_reg;
        look.len  = word_reg[WORD_W-1:hhfe_pkg::CODE_W];
        look.code = word_reg[hhfe_pkg::CODE_W-1:0];
    end

    `HHFE_ASSERT_IMPL(a_hit_len_nonzero, clk, rst_n, hit_reg, word_reg[WORD_W-1:hhfe_pkg::CODE_W] != '0)
    `HHFE_ASSERT_IMPL(a_hit_len_max, clk, rst_n, hit_reg, word_reg[WORD_W-1:hhfe_pkg::CODE_W] <= MAX_LEN)
    `HHFE_ASSERT_NEXT(a_load_sets_valid, clk, rst_n, do_load && (clen != '0), valid_reg[$past(slot_idx)])

endmodule

// ----- hw/rtl/hybrid_huffman_fallback_encoder.sv -----
// Top level of the hybrid Huffman / fixed-width fallback encoder.
//
// Items enter on the item channel (item_valid / item_stall): table loads,
// symbols, end-of-entry marks and flushes. Results leave on the result
// channel (result_valid / result_stall), one per transfer, with last set on
// the final result of each item. Configuration goes through cfg_valid /
// cfg_ready (always ready), index 0 fallback width, index 1 block size.
// An accepted item passes the input, lookup and result group registers
// before its first result. Throughput: one item per cycle without result
// stalls; the table match is combinational over per-slot key compares, the
// code memory read is registered, and packing is combinational into the
// result group register. A multi-result item holds that register until its
// last result is taken; the result port then paces at one result a cycle.
// A stall on the result side holds the group register; the item channel
// keeps accepting until the input, lookup and group stages are all full.
// Reset empties the code table, clears both streams and the counters, and
// sets fallback width 32 and block size 1024.
`timescale 1ns / 1ps
`include "hybrid_huffman_fallback_encoder_assert.svh"

module hybrid_huffman_fallback_encoder #(
    parameter int TABLE_SLOTS  = 64,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [1:0]                          command,
    input  logic [hhfe_pkg::SYM_W-1:0]          symbol,
    input  logic [hhfe_pkg::SLOT_W-1:0]         slot,
    input  logic [hhfe_pkg::CODE_W-1:0]         code_bits,
    input  logic [hhfe_pkg::LEN_W-1:0]          code_length,

    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [1:0]                          kind,
    output logic [7:0]                          data_byte,
    output logic [3:0]                          valid_bits,
    output logic [hhfe_pkg::CNT_W-1:0]          huff_count,
    output logic [hhfe_pkg::CNT_W-1:0]          entry_bits,
    output logic                                block_start,
    output logic [hhfe_pkg::OFS_W-1:0]          hi_offset,
    output logic [hhfe_pkg::OFS_W-1:0]          lo_offset,
    output logic                                last,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hhfe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hhfe_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int OW = hhfe_pkg::OFS_W;
    localparam int CW = hhfe_pkg::CNT_W;

    // Configuration registers
    logic [hhfe_pkg::FBW_W-1:0] fallback_width_reg;
    logic [hhfe_pkg::BSZ_W-1:0] block_size_reg;

    // Input stage
    logic                        s0_valid_reg;
    hhfe_pkg::cmd_t              cmd_reg;
    logic [hhfe_pkg::SYM_W-1:0]  symbol_reg;
    logic [hhfe_pkg::SLOT_W-1:0] slot_reg;
    logic [hhfe_pkg::CODE_W-1:0] code_bits_reg;
    logic [hhfe_pkg::LEN_W-1:0]  code_length_reg;

    // Lookup stage
    logic                        s1_valid_reg;
    hhfe_pkg::lookup_t           look;

    // Result group
    logic                              g_valid_reg;
    logic [hhfe_pkg::RES_CNT_W-1:0]    g_cnt_reg;
    logic [hhfe_pkg::RES_IDX_W-1:0]    rd_idx_reg;
    hhfe_pkg::result_t                 g_res_reg [hhfe_pkg::MAX_RESULTS];
    hhfe_pkg::result_t                 cur_res;

    // Stream and entry state
    logic [7:0]    hi_accum_reg, hi_accum_next;
    logic [2:0]    hi_fill_reg, hi_fill_next;
    logic [7:0]    lo_accum_reg, lo_accum_next;
    logic [2:0]    lo_fill_reg, lo_fill_next;
    logic [OW-1:0] hi_total_reg, hi_total_next;
    logic [OW-1:0] lo_total_reg, lo_total_next;
    logic [OW-1:0] hi_entry_start_reg, hi_entry_start_next;
    logic [OW-1:0] lo_entry_start_reg, lo_entry_start_next;
    logic [CW-1:0] entry_in_block_reg, entry_in_block_next;
    logic [CW-1:0] entry_symbols_reg, entry_symbols_next;
    logic [CW-1:0] entry_code_bits_reg, entry_code_bits_next;

    // Handshake
    logic accept, s0_adv, s1_adv, s1_ready, s0_ready;
    logic out_take, take_last, g_free;

    // Packing datapath
    logic [hhfe_pkg::FBW_W-1:0] fbw_eff;
    logic                       use_hi;
    logic [5:0]                 push_len;
    logic [31:0]                push_val;
    logic [31:0]                push_rev;
    logic [63:0]                rev_shifted;
    logic [5:0]                 rev_shamt;
    logic [7:0]                 cur_acc;
    logic [2:0]                 cur_fill;
    logic [39:0]                combined;
    logic [39:0]                combined_rest;
    logic [5:0]                 push_total;

    // Entry bookkeeping
    logic [hhfe_pkg::BSZ_W-1:0] bsz_eff;
    logic [CW:0]                eib_inc;
    logic                       first_in_block;

    logic [hhfe_pkg::RES_IDX_W-1:0] lo_pos, tot_pos;
    hhfe_pkg::result_t              res_next [hhfe_pkg::MAX_RESULTS];
    logic [hhfe_pkg::RES_CNT_W-1:0] res_cnt;

    function automatic logic [OW-1:0] sat_add48(input logic [OW-1:0] t, input logic [5:0] n);
        logic [OW:0] s;
        begin
            s = {1'b0, t} + (OW + 1)'(n);
            return s[OW] ? '1 : s[OW-1:0];
        end
    endfunction

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fallback_width_reg <= hhfe_pkg::DEFAULT_FBW;
            block_size_reg     <= hhfe_pkg::DEFAULT_BLOCK;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == hhfe_pkg::CFG_FALLBACK_WIDTH)
            begin
                fallback_width_reg <= cfg_data[hhfe_pkg::FBW_W-1:0];
            end
            else if (cfg_index == hhfe_pkg::CFG_BLOCK_SIZE)
            begin
                block_size_reg <= cfg_data[hhfe_pkg::BSZ_W-1:0];
            end
        end
    end

    // ---------------- flow control ----------------
    assign cur_res   = g_res_reg[rd_idx_reg];
    assign last      = ({1'b0, rd_idx_reg} + 3'd1) == g_cnt_reg;
    assign out_take  = g_valid_reg && !result_stall;
    assign take_last = out_take && last;
    assign g_free    = !g_valid_reg || take_last;
    assign s1_adv    = s1_valid_reg && g_free;
    assign s1_ready  = !s1_valid_reg || g_free;
    assign s0_adv    = s0_valid_reg && s1_ready;
    assign s0_ready  = !s0_valid_reg || s1_ready;
    assign item_stall = !s0_ready;
    assign accept    = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s0_valid_reg <= 1'b1;
            end
            else if (s0_adv)
            begin
                s0_valid_reg <= 1'b0;
            end
            if (s0_adv)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg         <= hhfe_pkg::cmd_t'(command);
            symbol_reg      <= symbol;
            slot_reg        <= slot;
            code_bits_reg   <= code_bits;
            code_length_reg <= code_length;
        end
    end

    hhfe_lookup #(
        .TABLE_SLOTS  (TABLE_SLOTS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_lookup (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (s0_adv),
        .cmd         (cmd_reg),
        .sym         (symbol_reg),
        .slot        (slot_reg),
        .code_bits   (code_bits_reg),
        .code_length (code_length_reg),
        .look        (look)
    );

    // ---------------- bit packing ----------------
    assign fbw_eff  = (fallback_width_reg > hhfe_pkg::MAX_FBW) ? hhfe_pkg::MAX_FBW
                                                               : fallback_width_reg;
    assign use_hi   = look.hit;
    assign push_len = use_hi ? look.len : fbw_eff;
    assign push_val = use_hi ? look.code : look.sym;
    assign cur_acc  = use_hi ? hi_accum_reg : lo_accum_reg;
    assign cur_fill = use_hi ? hi_fill_reg : lo_fill_reg;

    always_comb
    begin
        for (int j = 0; j < 32; j++)
        begin
            push_rev[j] = push_val[31 - j];
        end
    end

    // Reversed word shifted down leaves the first-sent bit at position zero.
    assign rev_shamt     = 6'd32 - push_len;
    assign rev_shifted   = {32'b0, push_rev} >> rev_shamt;
    assign combined      = {32'b0, cur_acc} | ({8'b0, rev_shifted[31:0]} << cur_fill);
    assign push_total    = {3'b0, cur_fill} + push_len;
    assign combined_rest = combined >> {push_total[5:3], 3'b000};

    assign bsz_eff        = (block_size_reg == '0) ? hhfe_pkg::DEFAULT_BLOCK : block_size_reg;
    assign eib_inc        = {1'b0, entry_in_block_reg} + (CW + 1)'(1);
    assign first_in_block = (entry_in_block_reg == '0);

    assign lo_pos  = hhfe_pkg::RES_IDX_W'(hi_fill_reg != 3'd0);
    assign tot_pos = lo_pos + hhfe_pkg::RES_IDX_W'(lo_fill_reg != 3'd0);

    always_comb
    begin
        for (int i = 0; i < hhfe_pkg::MAX_RESULTS; i++)
        begin
            res_next[i] = '0;
        end
        res_cnt              = '0;
        hi_accum_next        = hi_accum_reg;
        hi_fill_next         = hi_fill_reg;
        lo_accum_next        = lo_accum_reg;
        lo_fill_next         = lo_fill_reg;
        hi_total_next        = hi_total_reg;
        lo_total_next        = lo_total_reg;
        hi_entry_start_next  = hi_entry_start_reg;
        lo_entry_start_next  = lo_entry_start_reg;
        entry_in_block_next  = entry_in_block_reg;
        entry_symbols_next   = entry_symbols_reg;
        entry_code_bits_next = entry_code_bits_reg;

        case (look.cmd)
            hhfe_pkg::CMD_SYMBOL:
            begin
                for (int i = 0; i < hhfe_pkg::MAX_RESULTS; i++)
                begin
                    res_next[i].kind       = use_hi ? hhfe_pkg::KIND_HUFF
                                                    : hhfe_pkg::KIND_FALLBACK;
                    res_next[i].data_byte  = combined[8*i +: 8];
                    res_next[i].valid_bits = 4'd8;
                end
                res_cnt = push_total[5:3];
                if (use_hi)
                begin
                    hi_accum_next        = combined_rest[7:0];
                    hi_fill_next         = push_total[2:0];
                    hi_total_next        = sat_add48(hi_total_reg, push_len);
                    entry_symbols_next   = entry_symbols_reg + CW'(1);
                    entry_code_bits_next = entry_code_bits_reg + CW'(push_len);
                end
                else
                begin
                    lo_accum_next = combined_rest[7:0];
                    lo_fill_next  = push_total[2:0];
                    lo_total_next = sat_add48(lo_total_reg, push_len);
                end
            end
            hhfe_pkg::CMD_END_ENTRY:
            begin
                res_next[0].kind        = hhfe_pkg::KIND_RECORD;
                res_next[0].huff_count  = entry_symbols_reg;
                res_next[0].entry_bits  = entry_code_bits_reg;
                res_next[0].block_start = first_in_block;
                res_next[0].hi_offset   = first_in_block ? hi_entry_start_reg : '0;
                res_next[0].lo_offset   = first_in_block ? lo_entry_start_reg : '0;
                res_cnt                 = 3'd1;
                entry_in_block_next     = (eib_inc >= {1'b0, bsz_eff}) ? '0 : eib_inc[CW-1:0];
                entry_symbols_next      = '0;
                entry_code_bits_next    = '0;
                hi_entry_start_next     = hi_total_reg;
                lo_entry_start_next     = lo_total_reg;
            end
            hhfe_pkg::CMD_FLUSH:
            begin
                if (hi_fill_reg != 3'd0)
                begin
                    res_next[0].kind       = hhfe_pkg::KIND_HUFF;
                    res_next[0].data_byte  = hi_accum_reg;
                    res_next[0].valid_bits = {1'b0, hi_fill_reg};
                end
                if (lo_fill_reg != 3'd0)
                begin
                    res_next[lo_pos].kind       = hhfe_pkg::KIND_FALLBACK;
                    res_next[lo_pos].data_byte  = lo_accum_reg;
                    res_next[lo_pos].valid_bits = {1'b0, lo_fill_reg};
                end
                res_next[tot_pos].kind      = hhfe_pkg::KIND_TOTALS;
                res_next[tot_pos].hi_offset = hi_total_reg;
                res_next[tot_pos].lo_offset = lo_total_reg;
                res_cnt                     = {1'b0, tot_pos} + 3'd1;
                // Start a new run; the code table stays.
                hi_accum_next        = '0;
                hi_fill_next         = '0;
                lo_accum_next        = '0;
                lo_fill_next         = '0;
                hi_total_next        = '0;
                lo_total_next        = '0;
                hi_entry_start_next  = '0;
                lo_entry_start_next  = '0;
                entry_in_block_next  = '0;
                entry_symbols_next   = '0;
                entry_code_bits_next = '0;
            end
            default:
            begin
                res_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_accum_reg        <= '0;
            hi_fill_reg         <= '0;
            lo_accum_reg        <= '0;
            lo_fill_reg         <= '0;
            hi_total_reg        <= '0;
            lo_total_reg        <= '0;
            hi_entry_start_reg  <= '0;
            lo_entry_start_reg  <= '0;
            entry_in_block_reg  <= '0;
            entry_symbols_reg   <= '0;
            entry_code_bits_reg <= '0;
        end
        else if (s1_adv)
        begin
            hi_accum_reg        <= hi_accum_next;
            hi_fill_reg         <= hi_fill_next;
            lo_accum_reg        <= lo_accum_next;
            lo_fill_reg         <= lo_fill_next;
            hi_total_reg        <= hi_total_next;
            lo_total_reg        <= lo_total_next;
            hi_entry_start_reg  <= hi_entry_start_next;
            lo_entry_start_reg  <= lo_entry_start_next;
            entry_in_block_reg  <= entry_in_block_next;
            entry_symbols_reg   <= entry_symbols_next;
            entry_code_bits_reg <= entry_code_bits_next;
        end
    end

    // ---------------- result group ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
            g_cnt_reg   <= '0;
            rd_idx_reg  <= '0;
        end
        else if (s1_adv)
        begin
            g_valid_reg <= (res_cnt != '0);
            g_cnt_reg   <= res_cnt;
            rd_idx_reg  <= '0;
        end
        else if (take_last)
        begin
            g_valid_reg <= 1'b0;
            rd_idx_reg  <= '0;
        end
        else if (out_take)
        begin
            rd_idx_reg <= rd_idx_reg + hhfe_pkg::RES_IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            for (int i = 0; i < hhfe_pkg::MAX_RESULTS; i++)
            begin
                g_res_reg[i] <= res_next[i];
            end
        end
    end

    assign result_valid = g_valid_reg;
    assign kind         = cur_res.kind;
    assign data_byte    = cur_res.data_byte;
    assign valid_bits   = cur_res.valid_bits;
    assign huff_count   = cur_res.huff_count;
    assign entry_bits   = cur_res.entry_bits;
    assign block_start  = cur_res.block_start;
    assign hi_offset    = cur_res.hi_offset;
    assign lo_offset    = cur_res.lo_offset;

    `HHFE_ASSERT_IMPL(a_stall_only_full, clk, rst_n, item_stall, s0_valid_reg && s1_valid_reg && g_valid_reg)
    `HHFE_ASSERT_IMPL(a_rd_idx_in_group, clk, rst_n, g_valid_reg, {1'b0, rd_idx_reg} < g_cnt_reg)
    `HHFE_ASSERT_IMPL(a_accum_clean, clk, rst_n, 1'b1, ((hi_accum_reg >> hi_fill_reg) == 8'd0) && ((lo_accum_reg >> lo_fill_reg) == 8'd0))
    `HHFE_ASSERT_NEXT(a_flush_clears, clk, rst_n, s1_adv && (look.cmd == hhfe_pkg::CMD_FLUSH), (hi_total_reg == '0) && (lo_total_reg == '0) && (hi_fill_reg == '0) && (lo_fill_reg == '0))

endmodule
